// ===== src/chained_hash_set_macros.svh =====
// assertion macros used by the hash set top level
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH

// same-cycle implication under synchronous reset
`define CHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash set check failed");

// next-cycle implication under synchronous reset
`define CHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash set check failed");

`endif

// ===== src/chs_pkg.sv =====
package chs_pkg;

  localparam int KEY_W = 31;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_LOAD,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_FINISH,
    ST_ALLOC_RD,
    ST_ALLOC_WR,
    ST_REM_UNLINK,
    ST_REM_FREE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic head_rd;
    logic head_load;
    logic walk_rd;
    logic walk_next;
    logic walk_hit;
    logic set_full;
    logic alloc_rd;
    logic alloc_wr;
    logic rem_unlink;
    logic rem_free;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic walk_end;
    logic key_match;
    logic is_add;
    logic is_remove;
    logic found;
    logic pool_full;
  } sts_t;

endpackage

// ===== src/chs_ram.sv =====
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/chs_ctrl.sv =====
module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  import chs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:      if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:       if (start) state_next = ST_DIV;
      ST_DIV:        if (sts.div_last) state_next = ST_HEAD_RD;
      ST_HEAD_RD:    state_next = ST_HEAD_LOAD;
      ST_HEAD_LOAD:  state_next = ST_WALK_RD;
      ST_WALK_RD:    state_next = sts.walk_end ? ST_FINISH : ST_WALK_CMP;
      ST_WALK_CMP:   state_next = sts.key_match ? ST_FINISH : ST_WALK_RD;
      ST_FINISH: begin
        if (sts.is_add && !sts.found && !sts.pool_full) begin
          state_next = ST_ALLOC_RD;
        end else if (sts.is_remove && sts.found) begin
          state_next = ST_REM_UNLINK;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_ALLOC_RD:   state_next = ST_ALLOC_WR;
      ST_ALLOC_WR:   state_next = ST_RESP;
      ST_REM_UNLINK: state_next = ST_REM_FREE;
      ST_REM_FREE:   state_next = ST_RESP;
      ST_RESP:       state_next = ST_IDLE;
      default:       state_next = ST_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:      cmd.clr_step = 1'b1;
      ST_IDLE:       cmd.load = start;
      ST_DIV:        cmd.div_step = 1'b1;
      ST_HEAD_RD:    cmd.head_rd = 1'b1;
      ST_HEAD_LOAD:  cmd.head_load = 1'b1;
      ST_WALK_RD:    cmd.walk_rd = !sts.walk_end;
      ST_WALK_CMP: begin
        cmd.walk_hit  = sts.key_match;
        cmd.walk_next = !sts.key_match;
      end
      ST_FINISH:     cmd.set_full = sts.is_add && !sts.found && sts.pool_full;
      ST_ALLOC_RD:   cmd.alloc_rd = 1'b1;
      ST_ALLOC_WR:   cmd.alloc_wr = 1'b1;
      ST_REM_UNLINK: cmd.rem_unlink = 1'b1;
      ST_REM_FREE:   cmd.rem_free = 1'b1;
      default:       cmd = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESP);

endmodule

// ===== src/chs_dpath.sv =====
module chs_dpath #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  chs_pkg::cmd_t                   cmd,
  output chs_pkg::sts_t                   sts,
  input  logic [1:0]                      op,
  input  logic [chs_pkg::KEY_W-1:0]       key,
  input  logic                            cfg_we,
  input  logic [chs_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            found,
  output logic                            status,
  output logic [$clog2(NODES+1)-1:0]      count
);
  import chs_pkg::*;

  localparam int NW  = $clog2(NODES + 1);
  localparam int NIW = $clog2(NODES);
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int DW  = $clog2(BUCKETS + 1);
  localparam int CNW = $clog2(KEY_W);
  localparam logic [NW-1:0] NULL_LINK = NW'(NODES);

  logic [CFG_W-1:0] bucket_count;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [DW-1:0]    rem;
  logic [CNW-1:0]   div_cnt;
  logic [NW-1:0]    cur, prev, head_b, steps, hit, next_r;
  logic [NW-1:0]    free_head, fill, population;
  logic [BW-1:0]    clr_idx;
  logic             found_r, status_r;

  logic [DW-1:0]    eff;
  logic [DW:0]      trial;
  logic [BW-1:0]    bidx;
  logic             prev_valid, fresh;

  logic             head_we, link_we;
  logic [BW-1:0]    head_waddr;
  logic [NW-1:0]    head_wdata, head_rdata;
  logic [NIW-1:0]   link_waddr, link_raddr;
  logic [NW-1:0]    link_wdata, link_rdata;
  logic [KEY_W-1:0] key_rdata;

  // effective modulus: zero acts as one, clipped to the table size
  always_comb begin
    if (bucket_count == '0) begin
      eff = DW'(1);
    end else if (32'(bucket_count) > 32'(BUCKETS)) begin
      eff = DW'(BUCKETS);
    end else begin
      eff = DW'(bucket_count);
    end
  end

  assign trial      = {rem, key_r[div_cnt]};
  assign bidx       = rem[BW-1:0];
  assign prev_valid = (prev < NULL_LINK);
  assign fresh      = (free_head >= fill);

  // status to the controller
  always_comb begin
    sts.clr_last  = (clr_idx == BW'(BUCKETS - 1));
    sts.div_last  = (div_cnt == '0);
    sts.walk_end  = (cur >= NULL_LINK) || (steps == NULL_LINK);
    sts.key_match = (key_rdata == key_r);
    sts.is_add    = (op_r == OP_ADD);
    sts.is_remove = (op_r == OP_REMOVE);
    sts.found     = found_r;
    sts.pool_full = (free_head >= NULL_LINK);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CFG_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  // control state of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      free_head  <= '0;
      fill       <= '0;
      population <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + BW'(1);
      end
      if (cmd.alloc_wr) begin
        free_head  <= fresh ? free_head + NW'(1) : link_rdata;
        if (fresh) begin
          fill <= free_head + NW'(1);
        end
        population <= population + NW'(1);
      end
      if (cmd.rem_free) begin
        free_head <= hit;
        if (population != '0) begin
          population <= population - NW'(1);
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op;
      key_r    <= key;
      rem      <= '0;
      div_cnt  <= CNW'(KEY_W - 1);
      found_r  <= 1'b0;
      status_r <= 1'b0;
    end
    // one remainder bit per cycle
    if (cmd.div_step) begin
      rem     <= (trial >= {1'b0, eff}) ? DW'(trial - {1'b0, eff}) : trial[DW-1:0];
      div_cnt <= div_cnt - CNW'(1);
    end
    if (cmd.head_load) begin
      cur    <= head_rdata;
      head_b <= head_rdata;
      prev   <= NULL_LINK;
      steps  <= '0;
    end
    if (cmd.walk_next) begin
      prev  <= cur;
      cur   <= link_rdata;
      steps <= steps + NW'(1);
    end
    if (cmd.walk_hit) begin
      found_r <= 1'b1;
      hit     <= cur;
      next_r  <= link_rdata;
    end
    if (cmd.set_full) begin
      status_r <= 1'b1;
    end
  end

  // bucket head write port
  always_comb begin
    head_we    = cmd.clr_step || cmd.alloc_wr || (cmd.rem_unlink && !prev_valid);
    head_waddr = cmd.clr_step ? clr_idx : bidx;
    if (cmd.clr_step) begin
      head_wdata = NULL_LINK;
    end else if (cmd.alloc_wr) begin
      head_wdata = free_head;
    end else begin
      head_wdata = next_r;
    end
  end

  // node link ports
  always_comb begin
    link_we    = cmd.alloc_wr || (cmd.rem_unlink && prev_valid) || cmd.rem_free;
    link_raddr = cmd.alloc_rd ? free_head[NIW-1:0] : cur[NIW-1:0];
    if (cmd.alloc_wr) begin
      link_waddr = free_head[NIW-1:0];
      link_wdata = head_b;
    end else if (cmd.rem_unlink) begin
      link_waddr = prev[NIW-1:0];
      link_wdata = next_r;
    end else begin
      link_waddr = hit[NIW-1:0];
      link_wdata = free_head;
    end
  end

  chs_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (cmd.head_rd),
    .raddr (bidx),
    .rdata (head_rdata)
  );

  chs_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (cmd.walk_rd || cmd.alloc_rd),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  chs_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.alloc_wr),
    .waddr (free_head[NIW-1:0]),
    .wdata (key_r),
    .re    (cmd.walk_rd),
    .raddr (cur[NIW-1:0]),
    .rdata (key_rdata)
  );

  assign found  = found_r;
  assign status = status_r;
  assign count  = population;

endmodule

// ===== src/chained_hash_set.sv =====
// channel   | signals                          | transfer
// ----------+----------------------------------+-------------------------------
// command   | start, op, key                   | start high while busy low
// result    | found, status, count             | done high for one cycle
// config    | cfg_we, cfg_wdata                | cfg_we high, no wait
//
// busy stays high after a transfer through the bit-serial modulo of the key,
// the bucket head read, the chain walk (a read and a compare state per node
// for the registered key/link memory reads) and, for an add that stores or a
// remove that hits, the table update states; done marks the last busy cycle.
// after reset the bucket heads are cleared, one per cycle, all BUCKETS of
// them; busy stays high meanwhile. the receiver cannot stall results.
module chained_hash_set #(
  parameter int BUCKETS = 64,
  parameter int NODES   = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  op,
  input  logic [chs_pkg::KEY_W-1:0]   key,
  output logic                        busy,
  output logic                        done,
  output logic                        found,
  output logic                        status,
  output logic [$clog2(NODES+1)-1:0]  count,
  input  logic                        cfg_we,
  input  logic [chs_pkg::CFG_W-1:0]   cfg_wdata
);
  import chs_pkg::*;

  localparam int CW = $clog2(NODES + 1);

  cmd_t cmd;
  sts_t sts;

  chs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  chs_dpath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .key       (key),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .found     (found),
    .status    (status),
    .count     (count)
  );

`include "chained_hash_set_macros.svh"

  // checks
  `CHS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CHS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `CHS_ASSERT_IMPL(a_full_not_found, clk, rst, done && status, !found)
  `CHS_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CW'(NODES))

endmodule
